// ===== rtl/fbpa_pkg.sv =====
package fbpa_pkg;

    // Sizes of the free stack.
    localparam int FREE_DEPTH = 64;
    localparam int DEPTH_W    = $clog2(FREE_DEPTH + 1);
    localparam int IDX_W      = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;

    // Field widths.
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 13;
    localparam int COUNT_W    = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // An in-range offset is below unit_count * unit_size, so it fits in this width.
    localparam int OFF_W      = SIZE_W + COUNT_W;
    localparam int REM_CNT_W  = $clog2(OFF_W);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_RESET = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_BLOCKS = 3'd1,
        ST_RANGE     = 3'd2,
        ST_ALIGN     = 3'd3,
        ST_DOUBLE    = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_SIZE    = 2'd0,
        CFG_UNIT_COUNT   = 2'd1,
        CFG_BASE_ADDRESS = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        op_t               opcode;
        logic [ADDR_W-1:0] block_address;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  granted_address;
        logic [COUNT_W-1:0] blocks_in_use;
        logic               pool_full;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_RANGE,
        S_ALIGN,
        S_SCAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    mul;
        logic    rem_start;
        logic    pop_rd;
        logic    scan_first;
        logic    scan_next;
        logic    fin;
        status_t fin_status;
        logic    carve;
        logic    pop;
        logic    push;
        logic    rewind;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  opcode;
        logic no_blocks;
        logic depth_zero;
        logic in_range;
        logic rem_done;
        logic rem_zero;
        logic count_zero;
        logic scan_hit;
        logic scan_end;
        logic stack_full;
    } dp_stat_t;

endpackage

// ===== rtl/fixed_block_pool_allocator.sv =====
// Steps: allocate decodes, then carves a fresh block or reads and pops a freed one; reset pool
// and unused opcode finish at decode; free checks the range, then runs a 29-step remainder for
// alignment, then scans any free-stack entries in turn for a double free.
// One transaction at a time: busy falls as the result strobe rises, so the next one can start
// at the edge that takes the result; results cannot stall.
// Asynchronous active-low reset restores config defaults, clears the pool counters and idles the sequencer.
module fixed_block_pool_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fbpa_pkg::item_t                   item,
    output logic                              done,
    output fbpa_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    fbpa_pkg::ctrl_cmd_t cmd;
    fbpa_pkg::dp_stat_t  stat;

    // Sequencer.
    fbpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Pool registers, free stack and checks.
    fbpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

// ===== rtl/fbpa_rem.sv =====
module fbpa_rem (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fbpa_pkg::OFF_W-1:0]     dividend,
    input  logic [fbpa_pkg::SIZE_W-1:0]    divisor,
    output logic                           done,
    output logic                           zero
);

    logic                              active_reg;
    logic                              active_next;
    logic                              done_reg;
    logic                              done_next;
    logic [fbpa_pkg::REM_CNT_W-1:0]    cnt_reg;
    logic [fbpa_pkg::REM_CNT_W-1:0]    cnt_next;
    logic [fbpa_pkg::OFF_W-1:0]        shift_reg;
    logic [fbpa_pkg::OFF_W-1:0]        shift_next;
    logic [fbpa_pkg::SIZE_W-1:0]       rem_reg;
    logic [fbpa_pkg::SIZE_W-1:0]       rem_next;
    logic [fbpa_pkg::SIZE_W:0]         trial;
    logic [fbpa_pkg::SIZE_W:0]         diff;

    // One restoring step: bring in the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, shift_reg[fbpa_pkg::OFF_W-1]};
        diff  = trial - {1'b0, divisor};
        active_next = active_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        done_next   = active_reg && (cnt_reg == '0);
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = fbpa_pkg::REM_CNT_W'(fbpa_pkg::OFF_W - 1);
            shift_next  = dividend;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            shift_next = {shift_reg[fbpa_pkg::OFF_W-2:0], 1'b0};
            rem_next   = (trial >= {1'b0, divisor}) ? diff[fbpa_pkg::SIZE_W-1:0]
                                                    : trial[fbpa_pkg::SIZE_W-1:0];
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign zero = (rem_reg == '0);

endmodule

// ===== rtl/fbpa_dp.sv =====
module fbpa_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fbpa_pkg::item_t                   item,
    input  logic                              cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  fbpa_pkg::ctrl_cmd_t               cmd,
    output fbpa_pkg::dp_stat_t                stat,
    output fbpa_pkg::result_t                 result
);

    // Configuration registers.
    logic [fbpa_pkg::SIZE_W-1:0]       unit_size_reg;
    logic [fbpa_pkg::SIZE_W-1:0]       unit_size_next;
    logic [fbpa_pkg::COUNT_W-1:0]      unit_count_reg;
    logic [fbpa_pkg::COUNT_W-1:0]      unit_count_next;
    logic [fbpa_pkg::ADDR_W-1:0]       base_reg;
    logic [fbpa_pkg::ADDR_W-1:0]       base_next;

    // Pool state.
    logic [fbpa_pkg::COUNT_W-1:0]      count_reg;
    logic [fbpa_pkg::COUNT_W-1:0]      count_next;
    logic [fbpa_pkg::ADDR_W-1:0]       fresh_reg;
    logic [fbpa_pkg::ADDR_W-1:0]       fresh_next;
    logic [fbpa_pkg::DEPTH_W-1:0]      depth_reg;
    logic [fbpa_pkg::DEPTH_W-1:0]      depth_next;
    logic [fbpa_pkg::DEPTH_W-1:0]      scan_cnt_reg;
    logic [fbpa_pkg::DEPTH_W-1:0]      scan_cnt_next;

    // Transaction payload and working values.
    fbpa_pkg::op_t                     op_reg;
    logic [fbpa_pkg::ADDR_W-1:0]       addr_reg;
    logic [fbpa_pkg::OFF_W-1:0]        product_reg;
    logic [fbpa_pkg::ADDR_W-1:0]       rd_data_reg;
    fbpa_pkg::result_t                 result_reg;
    fbpa_pkg::result_t                 result_next;

    // Free stack memory.
    logic [fbpa_pkg::ADDR_W-1:0]       stack_mem [fbpa_pkg::FREE_DEPTH];
    logic                              mem_we;
    logic                              mem_re;
    logic [fbpa_pkg::IDX_W-1:0]        mem_waddr;
    logic [fbpa_pkg::IDX_W-1:0]        mem_raddr;

    logic                              cfg_hit;
    logic                              rewind;
    logic [fbpa_pkg::ADDR_W:0]         end_sum;
    logic [fbpa_pkg::ADDR_W-1:0]       offset;
    logic [fbpa_pkg::ADDR_W-1:0]       granted;
    logic                              rem_done;
    logic                              rem_zero;

    // Configuration decode; a write to a known register also rewinds the pool.
    always_comb
    begin
        unit_size_next  = unit_size_reg;
        unit_count_next = unit_count_reg;
        base_next       = base_reg;
        cfg_hit         = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fbpa_pkg::CFG_UNIT_SIZE:
                begin
                    unit_size_next = cfg_data[fbpa_pkg::SIZE_W-1:0];
                    cfg_hit        = 1'b1;
                end
                fbpa_pkg::CFG_UNIT_COUNT:
                begin
                    unit_count_next = cfg_data[fbpa_pkg::COUNT_W-1:0];
                    cfg_hit         = 1'b1;
                end
                fbpa_pkg::CFG_BASE_ADDRESS:
                begin
                    base_next = cfg_data[fbpa_pkg::ADDR_W-1:0];
                    cfg_hit   = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign rewind = cfg_hit || cmd.rewind;

    // Pool state updates.
    always_comb
    begin
        count_next = count_reg;
        fresh_next = fresh_reg;
        depth_next = depth_reg;
        granted    = '0;
        if (rewind)
        begin
            count_next = '0;
            fresh_next = base_next;
            depth_next = '0;
        end
        else if (cmd.carve)
        begin
            count_next = count_reg + 1'b1;
            fresh_next = fresh_reg + fbpa_pkg::ADDR_W'(unit_size_reg);
            granted    = fresh_reg;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg + 1'b1;
            depth_next = depth_reg - 1'b1;
            granted    = rd_data_reg;
        end
        else if (cmd.push)
        begin
            count_next = count_reg - 1'b1;
            depth_next = depth_reg + 1'b1;
        end
    end

    // Scan counter: the number of stack reads issued so far.
    always_comb
    begin
        scan_cnt_next = scan_cnt_reg;
        if (cmd.scan_first)
        begin
            scan_cnt_next = fbpa_pkg::DEPTH_W'(1);
        end
        else if (cmd.scan_next)
        begin
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end
    end

    // Result of the finished transaction.
    always_comb
    begin
        result_next = result_reg;
        if (cmd.fin)
        begin
            result_next.status          = cmd.fin_status;
            result_next.granted_address = granted;
            result_next.blocks_in_use   = count_next;
            result_next.pool_full       = (count_next >= unit_count_reg);
        end
    end

    // Memory port selection.
    always_comb
    begin
        mem_we    = cmd.push;
        mem_waddr = depth_reg[fbpa_pkg::IDX_W-1:0];
        mem_re    = cmd.pop_rd || cmd.scan_first || cmd.scan_next;
        if (cmd.pop_rd)
        begin
            mem_raddr = fbpa_pkg::IDX_W'(depth_reg - 1'b1);
        end
        else if (cmd.scan_next)
        begin
            mem_raddr = scan_cnt_reg[fbpa_pkg::IDX_W-1:0];
        end
        else
        begin
            mem_raddr = '0;
        end
    end

    // Range bound and offset for the free checks.
    assign end_sum = {1'b0, base_reg} + (fbpa_pkg::ADDR_W + 1)'(product_reg);
    assign offset  = addr_reg - base_reg;

    fbpa_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rem_start),
        .dividend (offset[fbpa_pkg::OFF_W-1:0]),
        .divisor  (unit_size_reg),
        .done     (rem_done),
        .zero     (rem_zero)
    );

    // Status back to the controller.
    always_comb
    begin
        stat.opcode     = op_reg;
        stat.no_blocks  = (count_reg >= unit_count_reg);
        stat.depth_zero = (depth_reg == '0);
        stat.in_range   = (addr_reg >= base_reg) && ({1'b0, addr_reg} < end_sum);
        stat.rem_done   = rem_done;
        stat.rem_zero   = rem_zero;
        stat.count_zero = (count_reg == '0);
        stat.scan_hit   = (rd_data_reg == addr_reg);
        stat.scan_end   = (scan_cnt_reg == depth_reg);
        stat.stack_full = (depth_reg >= fbpa_pkg::DEPTH_W'(fbpa_pkg::FREE_DEPTH));
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_size_reg  <= fbpa_pkg::SIZE_RESET;
            unit_count_reg <= '0;
            base_reg       <= '0;
            count_reg      <= '0;
            fresh_reg      <= '0;
            depth_reg      <= '0;
            scan_cnt_reg   <= '0;
        end
        else
        begin
            unit_size_reg  <= unit_size_next;
            unit_count_reg <= unit_count_next;
            base_reg       <= base_next;
            count_reg      <= count_next;
            fresh_reg      <= fresh_next;
            depth_reg      <= depth_next;
            scan_cnt_reg   <= scan_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= item.opcode;
            addr_reg <= item.block_address;
        end
        if (cmd.mul)
        begin
            product_reg <= fbpa_pkg::OFF_W'(unit_count_reg) * fbpa_pkg::OFF_W'(unit_size_reg);
        end
        result_reg <= result_next;
    end

    // Free stack: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= addr_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    assign result = result_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= fbpa_pkg::DEPTH_W'(fbpa_pkg::FREE_DEPTH))
        else $error("free stack depth beyond its size");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!stat.stack_full && !stat.count_zero))
        else $error("push onto a full stack or with no block in use");

    a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop || cmd.pop_rd) |-> !stat.depth_zero)
        else $error("pop from an empty free stack");

endmodule

// ===== rtl/fbpa_ctrl.sv =====
module fbpa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  fbpa_pkg::dp_stat_t     stat,
    output fbpa_pkg::ctrl_cmd_t    cmd,
    output logic                   busy,
    output logic                   done
);

    fbpa_pkg::state_t state_reg;
    fbpa_pkg::state_t state_next;
    logic             done_reg;

    // Next state and commands.
    always_comb
    begin
        cmd            = '0;
        cmd.fin_status = fbpa_pkg::ST_OK;
        state_next     = state_reg;
        unique case (state_reg)
            fbpa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = fbpa_pkg::S_DECODE;
                end
            end
            fbpa_pkg::S_DECODE:
            begin
                unique case (stat.opcode)
                    fbpa_pkg::OP_ALLOC:
                    begin
                        if (stat.no_blocks)
                        begin
                            cmd.fin        = 1'b1;
                            cmd.fin_status = fbpa_pkg::ST_NO_BLOCKS;
                            state_next     = fbpa_pkg::S_IDLE;
                        end
                        else if (!stat.depth_zero)
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = fbpa_pkg::S_POP;
                        end
                        else
                        begin
                            cmd.carve  = 1'b1;
                            cmd.fin    = 1'b1;
                            state_next = fbpa_pkg::S_IDLE;
                        end
                    end
                    fbpa_pkg::OP_FREE:
                    begin
                        cmd.mul    = 1'b1;
                        state_next = fbpa_pkg::S_RANGE;
                    end
                    fbpa_pkg::OP_RESET:
                    begin
                        cmd.rewind = 1'b1;
                        cmd.fin    = 1'b1;
                        state_next = fbpa_pkg::S_IDLE;
                    end
                    fbpa_pkg::OP_NONE:
                    begin
                        cmd.fin    = 1'b1;
                        state_next = fbpa_pkg::S_IDLE;
                    end
                endcase
            end
            fbpa_pkg::S_POP:
            begin
                cmd.pop    = 1'b1;
                cmd.fin    = 1'b1;
                state_next = fbpa_pkg::S_IDLE;
            end
            fbpa_pkg::S_RANGE:
            begin
                if (!stat.in_range)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = fbpa_pkg::ST_RANGE;
                    state_next     = fbpa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.rem_start = 1'b1;
                    state_next    = fbpa_pkg::S_ALIGN;
                end
            end
            fbpa_pkg::S_ALIGN:
            begin
                if (stat.rem_done)
                begin
                    if (!stat.rem_zero)
                    begin
                        cmd.fin        = 1'b1;
                        cmd.fin_status = fbpa_pkg::ST_ALIGN;
                        state_next     = fbpa_pkg::S_IDLE;
                    end
                    else if (stat.count_zero)
                    begin
                        cmd.fin        = 1'b1;
                        cmd.fin_status = fbpa_pkg::ST_DOUBLE;
                        state_next     = fbpa_pkg::S_IDLE;
                    end
                    else if (stat.depth_zero)
                    begin
                        cmd.push   = 1'b1;
                        cmd.fin    = 1'b1;
                        state_next = fbpa_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_first = 1'b1;
                        state_next     = fbpa_pkg::S_SCAN;
                    end
                end
            end
            fbpa_pkg::S_SCAN:
            begin
                // The read data holds the entry issued in the previous cycle.
                if (stat.scan_hit)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = fbpa_pkg::ST_DOUBLE;
                    state_next     = fbpa_pkg::S_IDLE;
                end
                else if (stat.scan_end)
                begin
                    cmd.fin    = 1'b1;
                    state_next = fbpa_pkg::S_IDLE;
                    if (stat.stack_full)
                    begin
                        cmd.fin_status = fbpa_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            default:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    // State register and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbpa_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.fin;
        end
    end

    assign busy = (state_reg != fbpa_pkg::S_IDLE);
    assign done = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == fbpa_pkg::S_IDLE))
        else $error("result strobe while a transaction is still in progress");

    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.carve, cmd.pop, cmd.push, cmd.rewind}))
        else $error("more than one pool update in one cycle");

    a_update_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.carve || cmd.pop || cmd.push) |-> (cmd.fin && cmd.fin_status == fbpa_pkg::ST_OK))
        else $error("pool update without a successful finish");

endmodule

// ===== sim/tb_fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;

    // Cycles with no transaction at either side before the run is abandoned.
    localparam int IDLE_LIMIT = 1000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    fbpa_pkg::item_t                 item = '0;
    logic                            done;
    fbpa_pkg::result_t               result;
    logic                            cfg_we = 1'b0;
    logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    fixed_block_pool_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the pool registers and state.
    logic [fbpa_pkg::SIZE_W-1:0]  cfg_unit_size = fbpa_pkg::SIZE_RESET;
    logic [fbpa_pkg::COUNT_W-1:0] cfg_unit_count = '0;
    logic [fbpa_pkg::ADDR_W-1:0]  cfg_base = '0;
    logic [fbpa_pkg::COUNT_W-1:0] pool_in_use = '0;
    logic [fbpa_pkg::ADDR_W-1:0]  pool_fresh = '0;
    int                           stack_top = 0;
    logic [fbpa_pkg::ADDR_W-1:0]  free_list [fbpa_pkg::FREE_DEPTH];

    // Requests waiting to be sent and replies the pool still owes.
    fbpa_pkg::item_t   pool_requests [$];
    fbpa_pkg::result_t pool_replies [$];

    int errors = 0;
    int items_taken = 0;
    int settings_used = 0;
    int grants = 0;
    int returns = 0;
    int refusals = 0;
    int stack_full_hits = 0;
    int double_free_hits = 0;
    logic took = 1'b0;

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR at %0t ns: %s", $time, msg);
    endfunction

    function automatic void pool_rewind();
        pool_in_use = '0;
        stack_top = 0;
        pool_fresh = cfg_base;
    endfunction

    // Works out the reply to one transaction and advances the shadow pool.
    function automatic fbpa_pkg::result_t pool_step(fbpa_pkg::item_t req);
        fbpa_pkg::result_t           r;
        fbpa_pkg::status_t           st;
        logic [63:0]                 region_end;
        logic [fbpa_pkg::ADDR_W-1:0] offset;
        logic                        on_stack;
        r = '0;
        st = fbpa_pkg::ST_OK;
        case (req.opcode)
            fbpa_pkg::OP_ALLOC:
            begin
                if (pool_in_use >= cfg_unit_count)
                    st = fbpa_pkg::ST_NO_BLOCKS;
                else
                begin
                    pool_in_use = pool_in_use + 1'b1;
                    if (stack_top > 0)
                    begin
                        stack_top--;
                        r.granted_address = free_list[stack_top];
                    end
                    else
                    begin
                        r.granted_address = pool_fresh;
                        pool_fresh = pool_fresh + 32'(cfg_unit_size);
                    end
                end
            end
            fbpa_pkg::OP_FREE:
            begin
                region_end = {32'b0, cfg_base} + 64'(cfg_unit_count) * 64'(cfg_unit_size);
                offset = req.block_address - cfg_base;
                on_stack = 1'b0;
                for (int i = 0; i < stack_top; i++)
                    if (free_list[i] == req.block_address)
                        on_stack = 1'b1;
                if (req.block_address < cfg_base || {32'b0, req.block_address} >= region_end)
                    st = fbpa_pkg::ST_RANGE;
                else if (cfg_unit_size == '0 || (offset % 32'(cfg_unit_size)) != 0)
                    st = fbpa_pkg::ST_ALIGN;
                else if (pool_in_use == '0 || on_stack)
                    st = fbpa_pkg::ST_DOUBLE;
                else if (stack_top >= fbpa_pkg::FREE_DEPTH)
                    st = fbpa_pkg::ST_FULL;
                else
                begin
                    free_list[stack_top] = req.block_address;
                    stack_top++;
                    pool_in_use = pool_in_use - 1'b1;
                end
            end
            fbpa_pkg::OP_RESET:
                pool_rewind();
            default:
                ;
        endcase
        r.status = st;
        r.blocks_in_use = pool_in_use;
        r.pool_full = (pool_in_use >= cfg_unit_count);
        return r;
    endfunction

    // Writes one register; the caller must keep the pool idle, the task does not check it; any write rewinds the pool.
    task automatic write_reg(fbpa_pkg::cfg_idx_t idx, logic [fbpa_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            fbpa_pkg::CFG_UNIT_SIZE:    cfg_unit_size = data[fbpa_pkg::SIZE_W-1:0];
            fbpa_pkg::CFG_UNIT_COUNT:   cfg_unit_count = data[fbpa_pkg::COUNT_W-1:0];
            fbpa_pkg::CFG_BASE_ADDRESS: cfg_base = data;
            default:                    ;
        endcase
        pool_rewind();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Upper bits of the narrow registers carry random junk that must be ignored.
    task automatic setup_pool(int size, int count, logic [fbpa_pkg::ADDR_W-1:0] base);
        write_reg(fbpa_pkg::CFG_UNIT_SIZE, ($urandom() & ~32'h1FFF) | 32'(size));
        write_reg(fbpa_pkg::CFG_UNIT_COUNT, ($urandom() & ~32'hFFFF) | 32'(count));
        write_reg(fbpa_pkg::CFG_BASE_ADDRESS, base);
        settings_used++;
    endtask

    task automatic push_req(fbpa_pkg::op_t op, logic [fbpa_pkg::ADDR_W-1:0] addr);
        fbpa_pkg::item_t req;
        req.opcode = op;
        req.block_address = addr;
        pool_requests.push_back(req);
    endtask

    // Waits until every request is sent and every reply has arrived.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pool_requests.size() != 0 || pool_replies.size() != 0 || start || busy);
        repeat (4) @(negedge clk);
    endtask

    // Mostly well-formed allocate and free traffic, with some malformed frees, resets and unused opcodes.
    task automatic queue_random(int n);
        int                          span;
        int                          pick;
        logic [fbpa_pkg::ADDR_W-1:0] stride;
        logic [fbpa_pkg::ADDR_W-1:0] addr;
        span = (cfg_unit_count == 0) ? 1 : ((cfg_unit_count > 96) ? 96 : int'(cfg_unit_count));
        stride = 32'(cfg_unit_size);
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            addr = $urandom();
            if (pick < 42)
                push_req(fbpa_pkg::OP_ALLOC, addr);
            else if (pick < 80)
                push_req(fbpa_pkg::OP_FREE, cfg_base + $urandom_range(0, span - 1) * stride);
            else if (pick < 84)
                push_req(fbpa_pkg::OP_FREE, cfg_base + $urandom_range(0, span - 1) * stride
                                  + $urandom_range(1, (stride > 1) ? stride - 1 : 1));
            else if (pick < 88)
            begin
                case ($urandom_range(0, 2))
                    0:       addr = cfg_base - 1;
                    1:       addr = cfg_base + 32'(cfg_unit_count) * stride;
                    default: addr = cfg_base + 32'(cfg_unit_count) * stride - 1;
                endcase
                push_req(fbpa_pkg::OP_FREE, addr);
            end
            else if (pick < 92)
                push_req(fbpa_pkg::OP_FREE, addr);
            else if (pick < 96)
                push_req(fbpa_pkg::OP_RESET, addr);
            else
                push_req(fbpa_pkg::OP_NONE, addr);
        end
    endtask

    // Driver: offers queued transactions in bursts with random gaps.
    int   burst_left = 4;
    int   gap_left = 0;
    int   bursts = 0;
    logic hold_for_drain = 1'b0;

    always @(negedge clk)
    begin
        fbpa_pkg::item_t nxt_item;
        logic            nxt_start;
        nxt_item = item;
        nxt_start = start;
        if (!rst_n)
            nxt_start = 1'b0;
        else if (!(start && !took))
        begin
            nxt_start = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (hold_for_drain && pool_replies.size() != 0)
                ;
            else if (pool_requests.size() != 0)
            begin
                hold_for_drain = 1'b0;
                nxt_item = pool_requests.pop_front();
                nxt_start = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    bursts++;
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    hold_for_drain = ($urandom_range(0, 5) == 0) || (bursts == 3);
                end
            end
        end
        start <= nxt_start;
        item <= nxt_item;
    end

    // Monitor: checks each reply against the oldest prediction, then predicts new ones.
    always @(posedge clk)
    begin
        fbpa_pkg::result_t want;
        fbpa_pkg::result_t got;
        if (!rst_n)
            took <= 1'b0;
        else
        begin
            took <= start && !busy;
            if (done)
            begin
                got = result;
                if (pool_replies.size() == 0)
                    flag_error($sformatf("reply with none pending: %p", got));
                else
                begin
                    want = pool_replies.pop_front();
                    if (got.status !== want.status)
                        flag_error($sformatf("status: expected %s, got %0d",
                                             want.status.name(), got.status));
                    if (got.granted_address !== want.granted_address)
                        flag_error($sformatf("granted_address: expected %h, got %h",
                                             want.granted_address, got.granted_address));
                    if (got.blocks_in_use !== want.blocks_in_use)
                        flag_error($sformatf("blocks_in_use: expected %0d, got %0d",
                                             want.blocks_in_use, got.blocks_in_use));
                    if (got.pool_full !== want.pool_full)
                        flag_error($sformatf("pool_full: expected %b, got %b",
                                             want.pool_full, got.pool_full));
                end
            end
            if (start && !busy)
            begin
                want = pool_step(item);
                pool_replies.push_back(want);
                items_taken++;
                if (want.status != fbpa_pkg::ST_OK)
                    refusals++;
                else if (item.opcode == fbpa_pkg::OP_ALLOC)
                    grants++;
                else if (item.opcode == fbpa_pkg::OP_FREE)
                    returns++;
                if (want.status == fbpa_pkg::ST_FULL)
                    stack_full_hits++;
                if (want.status == fbpa_pkg::ST_DOUBLE)
                    double_free_hits++;
            end
        end
    end

    // Watchdog on cycles with no transaction at either side.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int slot [96];
        int j;
        int tmp;
        int size;
        int count;
        logic [fbpa_pkg::ADDR_W-1:0] base;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Default registers hold no blocks at all.
        push_req(fbpa_pkg::OP_ALLOC, 32'h0);
        push_req(fbpa_pkg::OP_FREE, 32'h0);
        wait_idle();

        // Small pool: exhaustion, reuse, each free refusal but a full stack, rewind, unused opcode.
        setup_pool(16, 4, 32'h0000_1000);
        repeat (4) push_req(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
        push_req(fbpa_pkg::OP_ALLOC, 32'h0);
        push_req(fbpa_pkg::OP_FREE, 32'h0000_1010);
        push_req(fbpa_pkg::OP_FREE, 32'h0000_1010);
        push_req(fbpa_pkg::OP_FREE, 32'h0000_0FFF);
        push_req(fbpa_pkg::OP_FREE, 32'h0000_1040);
        push_req(fbpa_pkg::OP_FREE, 32'h0000_1004);
        push_req(fbpa_pkg::OP_ALLOC, 32'h0);
        push_req(fbpa_pkg::OP_FREE, 32'h0000_103F);
        push_req(fbpa_pkg::OP_RESET, 32'hFFFF_FFFF);
        push_req(fbpa_pkg::OP_FREE, 32'h0000_1000);
        push_req(fbpa_pkg::OP_NONE, 32'hFFFF_FFFF);
        push_req(fbpa_pkg::OP_ALLOC, 32'h0);
        wait_idle();

        // Zero unit size: empty region, every block at the same address.
        setup_pool(0, 5, 32'h0000_1000);
        push_req(fbpa_pkg::OP_ALLOC, 32'h0);
        push_req(fbpa_pkg::OP_ALLOC, 32'h0);
        push_req(fbpa_pkg::OP_FREE, 32'h0000_1000);
        wait_idle();

        // Fresh pointer wraps past the top of the address space.
        setup_pool(16, 3, 32'hFFFF_FFF0);
        repeat (3) push_req(fbpa_pkg::OP_ALLOC, 32'h0);
        push_req(fbpa_pkg::OP_FREE, 32'hFFFF_FFF0);
        push_req(fbpa_pkg::OP_FREE, 32'h0000_0000);
        wait_idle();

        // Fill the free stack to its depth and past it, then drain it again.
        setup_pool(8, 100, 32'h8000_0000);
        for (int i = 0; i < 80; i++)
        begin
            slot[i] = i;
            push_req(fbpa_pkg::OP_ALLOC, $urandom());
        end
        for (int i = 79; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = slot[i];
            slot[i] = slot[j];
            slot[j] = tmp;
        end
        for (int i = 0; i < 80; i++)
            push_req(fbpa_pkg::OP_FREE, 32'h8000_0000 + 32'(slot[i]) * 8);
        repeat (80) push_req(fbpa_pkg::OP_ALLOC, $urandom());
        wait_idle();

        // Random traffic over a range of settings, extremes included.
        for (int p = 0; p < 7; p++)
        begin
            base = $urandom();
            case (p)
                0:
                begin
                    size = 16;
                    count = 8;
                    base = 32'h0000_1000;
                end
                1:
                begin
                    size = 4096;
                    count = 65535;
                    base = 32'hFFFF_FFFF;
                end
                2:
                begin
                    size = 1;
                    count = 1;
                    base = 32'h0;
                end
                3:
                begin
                    size = 3;
                    count = 200;
                end
                4:
                begin
                    size = 0;
                    count = 10;
                end
                5:
                begin
                    size = 4096;
                    count = 0;
                end
                default:
                begin
                    size = $urandom_range(1, 4096);
                    count = $urandom_range(1, 120);
                end
            endcase
            setup_pool(size, count, base);
            queue_random(96);
            wait_idle();
        end

        // Let any late reply show up before closing the books.
        repeat (120) @(negedge clk);
        if (pool_replies.size() != 0)
            flag_error($sformatf("%0d replies never arrived", pool_replies.size()));

        $display("Covered %0d transactions over %0d pool settings: %0d grants, %0d frees,",
                 items_taken, settings_used, grants, returns);
        $display("%0d refusals (%0d double frees, %0d stack full); %0d errors.",
                 refusals, double_free_hits, stack_full_hits, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
